>>> src/rv32i_instruction_executor_macros.svh
// ----------------------------------------------------------------------------
// RV32I instruction executor assertion macros
// Concurrent assertion wrappers, empty when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef RV32I_INSTRUCTION_EXECUTOR_MACROS_SVH
`define RV32I_INSTRUCTION_EXECUTOR_MACROS_SVH

// Same-cycle implication
`ifndef SYNTH
`define RVX_ASSERT_SAME(lbl, clk, rst_n, a, b) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
		else $error("assertion failed");
`else
`define RVX_ASSERT_SAME(lbl, clk, rst_n, a, b)
`endif

// Next-cycle implication
`ifndef SYNTH
`define RVX_ASSERT_NEXT(lbl, clk, rst_n, a, b) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
		else $error("assertion failed");
`else
`define RVX_ASSERT_NEXT(lbl, clk, rst_n, a, b)
`endif

`endif

>>> src/rvx_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RV32I executor package
// Opcodes, function codes, shared structs and datapath helper functions.
// ----------------------------------------------------------------------------
package rvx_pkg;

	localparam int unsigned MEM_BYTES_DEF = 65536;

	localparam logic OPER_EXEC    = 1'b0;
	localparam logic OPER_PRELOAD = 1'b1;

	localparam logic [6:0] OPC_OP     = 7'h33;
	localparam logic [6:0] OPC_OPIMM  = 7'h13;
	localparam logic [6:0] OPC_LOAD   = 7'h03;
	localparam logic [6:0] OPC_STORE  = 7'h23;
	localparam logic [6:0] OPC_BRANCH = 7'h63;
	localparam logic [6:0] OPC_JAL    = 7'h6F;
	localparam logic [6:0] OPC_JALR   = 7'h67;
	localparam logic [6:0] OPC_LUI    = 7'h37;
	localparam logic [6:0] OPC_AUIPC  = 7'h17;
	localparam logic [6:0] OPC_SYSTEM = 7'h73;

	localparam logic [6:0] F7_ALT = 7'h20;

	localparam logic [2:0] F3_ADD  = 3'd0;
	localparam logic [2:0] F3_SLL  = 3'd1;
	localparam logic [2:0] F3_SLT  = 3'd2;
	localparam logic [2:0] F3_SLTU = 3'd3;
	localparam logic [2:0] F3_XOR  = 3'd4;
	localparam logic [2:0] F3_SR   = 3'd5;
	localparam logic [2:0] F3_OR   = 3'd6;
	localparam logic [2:0] F3_AND  = 3'd7;

	localparam logic [2:0] F3_LB  = 3'd0;
	localparam logic [2:0] F3_LH  = 3'd1;
	localparam logic [2:0] F3_LW  = 3'd2;
	localparam logic [2:0] F3_LBU = 3'd4;
	localparam logic [2:0] F3_LHU = 3'd5;

	localparam logic [2:0] F3_SB = 3'd0;
	localparam logic [2:0] F3_SH = 3'd1;
	localparam logic [2:0] F3_SW = 3'd2;

	localparam logic [2:0] F3_BEQ  = 3'd0;
	localparam logic [2:0] F3_BNE  = 3'd1;
	localparam logic [2:0] F3_BLT  = 3'd4;
	localparam logic [2:0] F3_BGE  = 3'd5;
	localparam logic [2:0] F3_BLTU = 3'd6;
	localparam logic [2:0] F3_BGEU = 3'd7;

	// Data memory access: byte address, bytes last+1 starting there
	typedef struct packed {
		logic        rd;
		logic        wr;
		logic [1:0]  last;
		logic [31:0] addr;
		logic [31:0] data;
	} rvx_memreq_t;

	// Execute stage result handed to write-back
	typedef struct packed {
		logic        rd_wr;
		logic [4:0]  rd;
		logic [31:0] val;
		logic        is_load;
		logic [2:0]  ld_f3;
		logic [31:0] next_pc;
		logic        halted;
	} rvx_wb_t;

	function automatic logic [31:0] alu(input logic [2:0] f3, input logic alt,
		input logic [31:0] a, input logic [31:0] b);
		logic [31:0] r;
		case (f3)
			F3_ADD:  r = alt ? a - b : a + b;
			F3_SLL:  r = a << b[4:0];
			F3_SLT:  r = {31'd0, $signed(a) < $signed(b)};
			F3_SLTU: r = {31'd0, a < b};
			F3_XOR:  r = a ^ b;
			F3_SR:   r = alt ? 32'($signed(a) >>> b[4:0]) : a >> b[4:0];
			F3_OR:   r = a | b;
			F3_AND:  r = a & b;
			default: r = a & b;
		endcase
		return r;
	endfunction

	function automatic logic [31:0] load_fmt(input logic [2:0] f3, input logic [31:0] w);
		logic [31:0] r;
		case (f3)
			F3_LB:   r = {{24{w[7]}}, w[7:0]};
			F3_LH:   r = {{16{w[15]}}, w[15:0]};
			F3_LW:   r = w;
			F3_LBU:  r = {24'd0, w[7:0]};
			F3_LHU:  r = {16'd0, w[15:0]};
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

>>> src/rvx_regfile.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RV32I executor register file
// 32 x 32 synchronous RAM, two registered read ports, one write port,
// zeroed by a sweep over all 32 entries after reset.
// ----------------------------------------------------------------------------
module rvx_regfile (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        rd_en,
	input  logic [4:0]  ra1,
	input  logic [4:0]  ra2,
	output logic [31:0] rdata1,
	output logic [31:0] rdata2,
	input  logic        we,
	input  logic [4:0]  wa,
	input  logic [31:0] wdata,
	output logic        busy
);

	logic [31:0] mem [32];
	logic [4:0]  clr_q;
	logic        busy_q;
	logic [31:0] rd1_q;
	logic [31:0] rd2_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q  <= '0;
			busy_q <= 1'b1;
		end else if (busy_q) begin
			clr_q <= clr_q + 5'd1;
			if (clr_q == 5'd31) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (busy_q) begin
			mem[clr_q] <= '0;
		end else if (we) begin
			mem[wa] <= wdata;
		end
		if (rd_en) begin
			rd1_q <= mem[ra1];
			rd2_q <= mem[ra2];
		end
	end

	assign rdata1 = rd1_q;
	assign rdata2 = rd2_q;
	assign busy   = busy_q;

endmodule

>>> src/rvx_datamem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RV32I executor data memory
// Four byte-lane RAMs; an access of up to four bytes touches each lane once,
// so misaligned and wrapping accesses need no second access. Zeroed by a sweep.
// ----------------------------------------------------------------------------
module rvx_datamem #(
	parameter int unsigned MEM_BYTES = rvx_pkg::MEM_BYTES_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  rvx_pkg::rvx_memreq_t req,
	output logic [31:0]         rdata,
	output logic                busy
);

	localparam int unsigned ROWS = MEM_BYTES / 4;
	localparam int unsigned RW   = $clog2(ROWS);

	logic [RW-1:0] clr_q;
	logic          busy_q;
	logic [1:0]    off;
	logic [RW-1:0] row;
	logic [1:0]    off_q;
	logic [7:0]    bq [4];

	assign off = req.addr[1:0];
	assign row = req.addr[RW+1:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q  <= '0;
			busy_q <= 1'b1;
		end else if (busy_q) begin
			clr_q <= clr_q + RW'(1);
			if (clr_q == RW'(ROWS - 1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.rd) begin
			off_q <= off;
		end
	end

	for (genvar b = 0; b < 4; b++) begin : g_lane
		localparam logic [1:0] LANE = 2'(b);
		logic [7:0]    mem [ROWS];
		logic [1:0]    rel;
		logic [RW-1:0] lrow;
		logic          wen;
		logic [7:0]    wbyte;
		logic [7:0]    rq;

		// lane below the start offset belongs to the next row
		assign rel   = LANE - off;
		assign lrow  = (LANE < off) ? row + RW'(1) : row;
		assign wen   = req.wr && (rel <= req.last);
		assign wbyte = req.data[{rel, 3'b000} +: 8];

		always_ff @(posedge clk) begin
			if (busy_q) begin
				mem[clr_q] <= '0;
			end else if (wen) begin
				mem[lrow] <= wbyte;
			end
			if (req.rd) begin
				rq <= mem[lrow];
			end
		end

		assign bq[b] = rq;
	end

	for (genvar k = 0; k < 4; k++) begin : g_rot
		assign rdata[8*k +: 8] = bq[2'(k) + off_q];
	end

	assign busy = busy_q;

endmodule

>>> src/rvx_exec.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RV32I executor execute stage
// Decodes one item, computes ALU result, branch target and memory request.
// ----------------------------------------------------------------------------
module rvx_exec (
	input  logic                operation,
	input  logic [31:0]         instruction,
	input  logic [13:0]         load_word_address,
	input  logic [31:0]         load_data,
	input  logic [31:0]         a,
	input  logic [31:0]         b,
	input  logic [31:0]         pc,
	input  logic                halt,
	output rvx_pkg::rvx_wb_t    res,
	output rvx_pkg::rvx_memreq_t mreq
);

	logic [6:0]  op;
	logic [2:0]  f3;
	logic [6:0]  f7;
	logic [4:0]  rd;
	logic [31:0] immi;
	logic [31:0] imms;
	logic [31:0] immb;
	logic [31:0] immj;
	logic [31:0] pc4;

	assign op   = instruction[6:0];
	assign f3   = instruction[14:12];
	assign f7   = instruction[31:25];
	assign rd   = instruction[11:7];
	assign immi = {{20{instruction[31]}}, instruction[31:20]};
	assign imms = {{20{instruction[31]}}, instruction[31:25], instruction[11:7]};
	assign immb = {{19{instruction[31]}}, instruction[31], instruction[7],
		instruction[30:25], instruction[11:8], 1'b0};
	assign immj = {{11{instruction[31]}}, instruction[31], instruction[19:12],
		instruction[20], instruction[30:21], 1'b0};
	assign pc4  = pc + 32'd4;

	always_comb begin
		logic        wr;
		logic        taken;
		wr          = 1'b0;
		taken       = 1'b0;
		res         = '0;
		res.next_pc = pc;
		res.halted  = halt;
		res.ld_f3   = f3;
		mreq        = '0;
		mreq.data   = b;
		if (operation == rvx_pkg::OPER_PRELOAD) begin
			mreq.wr   = 1'b1;
			mreq.last = 2'd3;
			mreq.addr = {16'd0, load_word_address, 2'b00};
			mreq.data = load_data;
		end else if (!halt) begin
			res.next_pc = pc4;
			case (op)
				rvx_pkg::OPC_OP: begin
					res.val = rvx_pkg::alu(f3, f7 == rvx_pkg::F7_ALT, a, b);
					wr      = 1'b1;
				end
				rvx_pkg::OPC_OPIMM: begin
					res.val = rvx_pkg::alu(f3, (f3 == rvx_pkg::F3_SR) && instruction[30],
						a, immi);
					wr      = 1'b1;
				end
				rvx_pkg::OPC_LOAD: begin
					mreq.addr = a + immi;
					case (f3)
						rvx_pkg::F3_LB, rvx_pkg::F3_LH, rvx_pkg::F3_LW,
						rvx_pkg::F3_LBU, rvx_pkg::F3_LHU: begin
							mreq.rd     = 1'b1;
							res.is_load = 1'b1;
							wr          = 1'b1;
						end
						default: wr = 1'b0;
					endcase
				end
				rvx_pkg::OPC_STORE: begin
					mreq.addr = a + imms;
					case (f3)
						rvx_pkg::F3_SB: begin mreq.wr = 1'b1; mreq.last = 2'd0; end
						rvx_pkg::F3_SH: begin mreq.wr = 1'b1; mreq.last = 2'd1; end
						rvx_pkg::F3_SW: begin mreq.wr = 1'b1; mreq.last = 2'd3; end
						default: mreq.wr = 1'b0;
					endcase
				end
				rvx_pkg::OPC_BRANCH: begin
					case (f3)
						rvx_pkg::F3_BEQ:  taken = (a == b);
						rvx_pkg::F3_BNE:  taken = (a != b);
						rvx_pkg::F3_BLT:  taken = ($signed(a) < $signed(b));
						rvx_pkg::F3_BGE:  taken = !($signed(a) < $signed(b));
						rvx_pkg::F3_BLTU: taken = (a < b);
						rvx_pkg::F3_BGEU: taken = (a >= b);
						default:          taken = 1'b0;
					endcase
					if (taken) begin
						res.next_pc = pc + immb;
					end
				end
				rvx_pkg::OPC_JAL: begin
					res.val     = pc4;
					wr          = 1'b1;
					res.next_pc = pc + immj;
				end
				rvx_pkg::OPC_JALR: begin
					res.val     = pc4;
					wr          = 1'b1;
					res.next_pc = (a + immi) & ~32'd1;
				end
				rvx_pkg::OPC_LUI: begin
					res.val = {instruction[31:12], 12'd0};
					wr      = 1'b1;
				end
				rvx_pkg::OPC_AUIPC: begin
					res.val = pc + {instruction[31:12], 12'd0};
					wr      = 1'b1;
				end
				default: begin
					// system and unknown opcodes stop the core in place
					res.halted  = 1'b1;
					res.next_pc = pc;
				end
			endcase
		end
		res.rd_wr = wr && (rd != 5'd0);
		if (res.rd_wr) begin
			res.rd = rd;
		end else begin
			res.val     = '0;
			res.is_load = 1'b0;
		end
	end

endmodule

>>> src/rv32i_instruction_executor.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RV32I instruction executor
// Three-step pipeline around register file and byte-lane data memory RAMs.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel (req_valid/req_ready) carries one transaction per item:
//   execute an instruction word (fetched by the driver at the current pc) or
//   preload one little-endian word into data memory.
//   Response channel (rsp_valid/rsp_ready) returns one transaction per item:
//   next pc, halted flag and the destination register write, if any.
// Timing:
//   A request is registered at accept, its result at execute and its
//   response at write-back. One transaction per cycle is sustained while
//   responses are taken, including load-use and branch chains; the register
//   file is read at accept and the data memory read at execute.
// Reset:
//   Register file (all 32 entries) and data memory (MEM_BYTES/4 rows, 16384
//   by default) are swept to zero; req_ready stays low until both finish.
// Stall:
//   A held response freezes write-back, then execute, then accept; nothing is
//   dropped and the last response is held until taken.
// ----------------------------------------------------------------------------
`include "rv32i_instruction_executor_macros.svh"

module rv32i_instruction_executor #(
	parameter int unsigned MEM_BYTES = rvx_pkg::MEM_BYTES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	output logic        req_ready,
	input  logic        operation,
	input  logic [31:0] instruction,
	input  logic [13:0] load_word_address,
	input  logic [31:0] load_data,
	output logic        rsp_valid,
	input  logic        rsp_ready,
	output logic [31:0] next_pc,
	output logic        halted,
	output logic        dest_written,
	output logic [4:0]  dest_index,
	output logic [31:0] dest_value
);

	// execute stage payload
	logic        v_s1;
	logic        op_s1;
	logic [31:0] inst_s1;
	logic [13:0] lwa_s1;
	logic [31:0] ld_s1;

	// write-back stage payload
	logic             v_s2;
	rvx_pkg::rvx_wb_t res_s2;

	// architectural state kept in flops
	logic [31:0] pc_q;
	logic        halt_q;

	// last register file write, for the read that collided with it
	logic        wbv_q;
	logic [4:0]  wbi_q;
	logic [31:0] wbd_q;

	// response register
	logic        rsp_valid_q;
	logic [31:0] next_pc_q;
	logic        halted_q;
	logic        dest_written_q;
	logic [4:0]  dest_index_q;
	logic [31:0] dest_value_q;

	logic                 accept;
	logic                 s1_adv;
	logic                 s2_adv;
	logic                 out_free;
	logic                 rf_busy;
	logic                 dm_busy;
	logic [31:0]          rf_a;
	logic [31:0]          rf_b;
	logic [31:0]          a_fwd;
	logic [31:0]          b_fwd;
	logic [31:0]          mem_rdata;
	logic [31:0]          wb_val;
	logic                 rf_we;
	rvx_pkg::rvx_wb_t     res_ex;
	rvx_pkg::rvx_memreq_t mreq_ex;
	rvx_pkg::rvx_memreq_t mreq;

	// handshake: each step moves when the one after it has room; accept also waits out the reset sweeps
	assign out_free  = !rsp_valid_q || rsp_ready;
	assign s2_adv    = v_s2 && out_free;
	assign s1_adv    = v_s1 && (!v_s2 || s2_adv);
	assign req_ready = !rf_busy && !dm_busy && (!v_s1 || s1_adv);
	assign accept    = req_valid && req_ready;

	// operands are read as the request is taken
	rvx_regfile u_regfile (
		.clk    (clk),
		.arst_n (arst_n),
		.rd_en  (accept),
		.ra1    (instruction[19:15]),
		.ra2    (instruction[24:20]),
		.rdata1 (rf_a),
		.rdata2 (rf_b),
		.we     (rf_we),
		.wa     (res_s2.rd),
		.wdata  (wb_val),
		.busy   (rf_busy)
	);

	// forward from write-back first, then from the write that raced the read
	always_comb begin
		a_fwd = rf_a;
		b_fwd = rf_b;
		if (wbv_q && (wbi_q == inst_s1[19:15])) begin
			a_fwd = wbd_q;
		end
		if (wbv_q && (wbi_q == inst_s1[24:20])) begin
			b_fwd = wbd_q;
		end
		if (v_s2 && res_s2.rd_wr && (res_s2.rd == inst_s1[19:15])) begin
			a_fwd = wb_val;
		end
		if (v_s2 && res_s2.rd_wr && (res_s2.rd == inst_s1[24:20])) begin
			b_fwd = wb_val;
		end
	end

	rvx_exec u_exec (
		.operation         (op_s1),
		.instruction       (inst_s1),
		.load_word_address (lwa_s1),
		.load_data         (ld_s1),
		.a                 (a_fwd),
		.b                 (b_fwd),
		.pc                (pc_q),
		.halt              (halt_q),
		.res               (res_ex),
		.mreq              (mreq_ex)
	);

	// memory acts only as the item leaves execute, keeping accesses in order
	always_comb begin
		mreq    = mreq_ex;
		mreq.rd = mreq_ex.rd && s1_adv;
		mreq.wr = mreq_ex.wr && s1_adv;
	end

	rvx_datamem #(
		.MEM_BYTES (MEM_BYTES)
	) u_datamem (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mreq),
		.rdata  (mem_rdata),
		.busy   (dm_busy)
	);

	assign wb_val = res_s2.is_load ? rvx_pkg::load_fmt(res_s2.ld_f3, mem_rdata) : res_s2.val;
	assign rf_we  = s2_adv && res_s2.rd_wr;

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			pc_q        <= '0;
			halt_q      <= 1'b0;
			wbv_q       <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				v_s1 <= 1'b1;
			end else if (s1_adv) begin
				v_s1 <= 1'b0;
			end
			if (s1_adv) begin
				v_s2   <= 1'b1;
				pc_q   <= res_ex.next_pc;
				halt_q <= res_ex.halted;
			end else if (s2_adv) begin
				v_s2 <= 1'b0;
			end
			if (rf_we) begin
				wbv_q <= 1'b1;
			end
			if (s2_adv) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// payload: hold unless the stage moves
	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1   <= operation;
			inst_s1 <= instruction;
			lwa_s1  <= load_word_address;
			ld_s1   <= load_data;
		end
		if (s1_adv) begin
			res_s2 <= res_ex;
		end
		if (rf_we) begin
			wbi_q <= res_s2.rd;
			wbd_q <= wb_val;
		end
		if (s2_adv) begin
			next_pc_q      <= res_s2.next_pc;
			halted_q       <= res_s2.halted;
			dest_written_q <= res_s2.rd_wr;
			dest_index_q   <= res_s2.rd;
			dest_value_q   <= wb_val;
		end
	end

	assign rsp_valid    = rsp_valid_q;
	assign next_pc      = next_pc_q;
	assign halted       = halted_q;
	assign dest_written = dest_written_q;
	assign dest_index   = dest_index_q;
	assign dest_value   = dest_value_q;

	`RVX_ASSERT_SAME(a_no_accept_in_sweep, clk, arst_n, rf_busy || dm_busy, !req_ready)
	`RVX_ASSERT_NEXT(a_halt_sticks, clk, arst_n, halt_q, halt_q)
	`RVX_ASSERT_SAME(a_no_x0_write, clk, arst_n, rf_we, res_s2.rd != 5'd0)
	`RVX_ASSERT_SAME(a_index_only_on_write, clk, arst_n, rsp_valid && !dest_written,
		dest_index == 5'd0 && dest_value == 32'd0)

endmodule
